/* src/rla_pkg.sv */
// Shared types, sizes and helpers for the resend lock arbiter.
// No dependencies; every other file refers to this package by scoped names.

package rla_pkg;

	localparam int unsigned ENTRIES = 64;
	localparam int unsigned IDX_W   = $clog2(ENTRIES);
	localparam int unsigned ID_W    = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_PREFERRED = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = CFG_IDX_W'(1);

	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic             clr;
		logic             step;
		logic [IDX_W-1:0] idx;
	} scan_ctl_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  found_idx;
		logic              free_found;
		logic [IDX_W-1:0]  free_idx;
		logic              hold_found;
		logic [TIME_W-1:0] hold_age;
		logic [IDX_W-1:0]  all_idx;
		logic [TIME_W-1:0] all_age;
		logic [ID_W-1:0]   all_id;
		logic              ex_have;
		logic [TIME_W-1:0] ex_age;
		logic [ID_W-1:0]   ex_id;
		logic [IDX_W-1:0]  ex_idx;
	} scan_res_t;

	// Older wins; equal age goes to the lower id.
	function automatic logic older(input logic [TIME_W-1:0] age_a,
	                               input logic [ID_W-1:0]   id_a,
	                               input logic [TIME_W-1:0] age_b,
	                               input logic [ID_W-1:0]   id_b);
		older = (age_a > age_b) || ((age_a == age_b) && (id_a < id_b));
	endfunction

endpackage

/* src/rla_cell.sv */
// One evidence table entry: valid flag, originator id and time stamp.
// Depends on rla_pkg for the entry type.

module rla_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  rla_pkg::entry_t nxt,
	input  logic            wr,
	input  rla_pkg::entry_t wr_data,
	output rla_pkg::entry_t ent
);

	logic                       valid_q;
	logic [rla_pkg::ID_W-1:0]   id_q;
	logic [rla_pkg::TIME_W-1:0] stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= 1'b1;
		end else if (shift) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			id_q    <= wr_data.id;
			stamp_q <= wr_data.stamp;
		end else if (shift) begin
			id_q    <= nxt.id;
			stamp_q <= nxt.stamp;
		end
	end

	assign ent = '{valid: valid_q, id: id_q, stamp: stamp_q};

endmodule

/* src/rla_chain.sv */
// Ring of evidence cells; rotates one place towards cell 0 per shift.
// Depends on rla_pkg and rla_cell.

module rla_chain (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      shift,
	input  logic                      wr,
	input  logic [rla_pkg::IDX_W-1:0] wr_idx,
	input  rla_pkg::entry_t           wr_data,
	output rla_pkg::entry_t           head
);

	rla_pkg::entry_t ents [rla_pkg::ENTRIES];

	for (genvar i = 0; i < rla_pkg::ENTRIES; i++) begin : g_cell
		rla_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.nxt     (ents[(i + 1) % rla_pkg::ENTRIES]),
			.wr      (wr && (wr_idx == rla_pkg::IDX_W'(i))),
			.wr_data (wr_data),
			.ent     (ents[i])
		);
	end

	assign head = ents[0];

endmodule

/* src/rla_scan.sv */
// Head evaluator: watches the entry at cell 0 during a rotation and keeps
// lookup hits, first free slot, holder age and eviction candidates. Uses rla_pkg.

module rla_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rla_pkg::scan_ctl_t         ctl,
	input  rla_pkg::entry_t            head,
	input  logic [rla_pkg::ID_W-1:0]   req,
	input  logic [rla_pkg::TIME_W-1:0] now,
	input  logic [rla_pkg::ID_W-1:0]   old_holder,
	output rla_pkg::scan_res_t         res
);

	logic                        found_q, free_q, hold_q, all_have_q, ex_have_q;
	logic [rla_pkg::IDX_W-1:0]   found_idx_q, free_idx_q, all_idx_q, ex_idx_q;
	logic [rla_pkg::TIME_W-1:0]  hold_age_q, all_age_q, ex_age_q;
	logic [rla_pkg::ID_W-1:0]    all_id_q, ex_id_q;
	logic [rla_pkg::TIME_W-1:0]  age;
	logic                        is_old, ex_ok, take_all, take_ex;

	always_comb begin
		age      = now - head.stamp;
		is_old   = (old_holder != '0) && (head.id == old_holder);
		ex_ok    = head.valid && !is_old;
		take_all = head.valid &&
		           (!all_have_q || rla_pkg::older(age, head.id, all_age_q, all_id_q));
		take_ex  = ex_ok &&
		           (!ex_have_q || rla_pkg::older(age, head.id, ex_age_q, ex_id_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			hold_q     <= 1'b0;
			all_have_q <= 1'b0;
			ex_have_q  <= 1'b0;
		end else if (ctl.clr) begin
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			hold_q     <= 1'b0;
			all_have_q <= 1'b0;
			ex_have_q  <= 1'b0;
		end else if (ctl.step) begin
			if (head.valid && head.id == req) found_q <= 1'b1;
			if (!head.valid) free_q <= 1'b1;
			if (head.valid && is_old) hold_q <= 1'b1;
			if (take_all) all_have_q <= 1'b1;
			if (take_ex) ex_have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (head.valid && head.id == req) found_idx_q <= ctl.idx;
			if (!head.valid && !free_q) free_idx_q <= ctl.idx;
			if (head.valid && is_old) hold_age_q <= age;
			if (take_all) begin
				all_age_q <= age;
				all_id_q  <= head.id;
				all_idx_q <= ctl.idx;
			end
			if (take_ex) begin
				ex_age_q <= age;
				ex_id_q  <= head.id;
				ex_idx_q <= ctl.idx;
			end
		end
	end

	assign res = '{found: found_q, found_idx: found_idx_q,
	               free_found: free_q, free_idx: free_idx_q,
	               hold_found: hold_q, hold_age: hold_age_q,
	               all_idx: all_idx_q, all_age: all_age_q, all_id: all_id_q,
	               ex_have: ex_have_q, ex_age: ex_age_q, ex_id: ex_id_q,
	               ex_idx: ex_idx_q};

endmodule

/* src/resend_lock_arbiter.sv */
// Resend lock arbiter top level: control sequencer, configuration registers,
// lock arbitration and result register. Depends on rla_pkg, rla_chain, rla_scan.
//
//  channel   handshake              beat contents
//  -------   ---------------------  ----------------------------------------
//  in        in_valid / in_stall    requester_id, now_time
//  out       out_valid / out_stall  holder_id, holder_changed, entry_evicted
//  cfg       cfg_valid / cfg_ready  cfg_index (0 preferred id, 1 timeout),
//                                   cfg_data
//
// Per input beat the evidence ring rotates once through the head evaluator,
// then a decide cycle writes the table and loads the result register.
// Reset clears every valid flag at once, the holder and both registers.
// in_stall is high from acceptance until the decide cycle completes; a
// result held by out_stall blocks only the decide cycle of the next beat.

module resend_lock_arbiter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rla_pkg::ID_W-1:0]       requester_id,
	input  logic [rla_pkg::TIME_W-1:0]     now_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rla_pkg::ID_W-1:0]       holder_id,
	output logic                           holder_changed,
	output logic                           entry_evicted,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rla_pkg::CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE} state_t;

	state_t                     state_q;
	logic [rla_pkg::IDX_W-1:0]  cnt_q;
	logic [rla_pkg::ID_W-1:0]   req_q, old_q, holder_q, pref_q;
	logic [rla_pkg::TIME_W-1:0] now_q, tmo_q;
	logic                       out_valid_q, changed_q, evicted_q;
	logic [rla_pkg::ID_W-1:0]   out_holder_q;

	rla_pkg::entry_t    head;
	rla_pkg::scan_ctl_t ctl;
	rla_pkg::scan_res_t res;

	logic                       accept, leave, pending, wr;
	logic [rla_pkg::IDX_W-1:0]  wr_idx;
	logic [rla_pkg::ID_W-1:0]   new_holder;
	rla_pkg::entry_t            wr_data;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Decide cycle may finish once the result register is free or draining.
	assign leave = (state_q == ST_DECIDE) && !(out_valid_q && out_stall);

	assign ctl = '{clr: accept, step: (state_q == ST_SCAN), idx: cnt_q};

	rla_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.shift   (ctl.step),
		.wr      (wr),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.head    (head)
	);

	rla_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.head       (head),
		.req        (req_q),
		.now        (now_q),
		.old_holder (old_q),
		.res        (res)
	);

	// Arbitration and table write for the decide cycle.
	always_comb begin
		new_holder = old_q;
		if (pref_q != '0 && req_q == pref_q) begin
			new_holder = req_q;
		end else if (old_q == '0) begin
			new_holder = req_q;
		end else if (old_q != req_q && old_q != pref_q) begin
			// drop a holder with no evidence or evidence at or past the timeout
			if (!res.hold_found || res.hold_age >= tmo_q) new_holder = req_q;
		end

		pending = !res.found && !res.free_found;
		wr      = 1'b0;
		wr_idx  = res.found_idx;
		if (res.found) begin
			wr = 1'b1;
		end else if (res.free_found) begin
			wr     = 1'b1;
			wr_idx = res.free_idx;
		end else if (new_holder != '0 && new_holder == req_q) begin
			// requester holds the lock, so it cannot be the victim
			wr     = 1'b1;
			wr_idx = res.all_idx;
		end else if (new_holder == '0) begin
			// lock left free: every entry competes with the requester
			if (rla_pkg::older(res.all_age, res.all_id, '0, req_q)) begin
				wr     = 1'b1;
				wr_idx = res.all_idx;
			end
		end else if (res.ex_have &&
		             rla_pkg::older(res.ex_age, res.ex_id, '0, req_q)) begin
			wr     = 1'b1;
			wr_idx = res.ex_idx;
		end
		wr      = wr && leave;
		wr_data = '{valid: 1'b1, id: req_q, stamp: now_q};
	end

	// Sequencer, configuration and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			holder_q    <= '0;
			pref_q      <= '0;
			tmo_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rla_pkg::REG_PREFERRED: pref_q <= cfg_data[rla_pkg::ID_W-1:0];
					rla_pkg::REG_TIMEOUT:   tmo_q  <= cfg_data[rla_pkg::TIME_W-1:0];
					default: ;
				endcase
			end

			if (leave) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					// advance one entry per cycle until the ring is back home
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rla_pkg::IDX_W'(rla_pkg::ENTRIES - 1)) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (leave) begin
						holder_q <= new_holder;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Hold the request fields and the result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= requester_id;
			now_q <= now_time;
			old_q <= holder_q;
		end
		if (leave) begin
			out_holder_q <= new_holder;
			changed_q    <= (new_holder != old_q);
			evicted_q    <= pending;
		end
	end

	assign out_valid      = out_valid_q;
	assign holder_id      = out_holder_q;
	assign holder_changed = changed_q;
	assign entry_evicted  = evicted_q;

endmodule
